// ===== hdl/line_follow_pid_steering_macros.svh =====
// ----------------------------------------------------------------------------
// Line follower PID steering: assertion macros
// Shorthand for the concurrent checks in the steering engine.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_STEERING_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LFPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfps check failed");

// Next-cycle implication, disabled while reset is low.
`define LFPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfps check failed");

`endif

// ===== hdl/lfps_pkg.sv =====
// ----------------------------------------------------------------------------
// Line follower PID steering: package
// Widths, reset values, register indexes, shared types and saturation helper.
// ----------------------------------------------------------------------------
package lfps_pkg;

    localparam int HISTORY_DEPTH = 5;

    localparam int SAMPLE_W   = 10;
    localparam int SCALE_W    = 10;
    localparam int TARGET_W   = 10;
    localparam int GAIN_W     = 16;
    localparam int BASE_W     = 8;
    localparam int POWER_W    = 16;
    localparam int HIST_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Error in Q.8: target*256 minus sample*scale, with room for the sign.
    localparam int ERR_W  = SAMPLE_W + SCALE_W + 2;
    localparam int TRAP_W = HIST_W + $clog2(HISTORY_DEPTH) + 2;
    localparam int DIFF_W = HIST_W + 9;
    localparam int MULB_W = (TRAP_W > DIFF_W) ? TRAP_W : DIFF_W;
    localparam int PROD_W = GAIN_W + MULB_W;
    localparam int ACC_W  = PROD_W + 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reset calibration: target sits at half of the black-to-white span.
    localparam int BRIGHT_SPAN = 160;
    localparam logic [TARGET_W-1:0]      TARGET_RESET = TARGET_W'(BRIGHT_SPAN / 2);
    localparam logic [SCALE_W-1:0]       SCALE_RESET  = SCALE_W'(256);
    localparam logic signed [GAIN_W-1:0] KP_RESET     = GAIN_W'(256);
    localparam logic signed [GAIN_W-1:0] KI_RESET     = '0;
    localparam logic signed [GAIN_W-1:0] KD_RESET     = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 3'd0,
        CFG_SCALE  = 3'd1,
        CFG_KP     = 3'd2,
        CFG_KI     = 3'd3,
        CFG_KD     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [SCALE_W-1:0]  scale;
    } t_sensor_cfg;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } t_gains;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err_q8;
        logic signed [BASE_W-1:0] base;
        logic                     edge_neg;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_P,
        BK_MUL_I,
        BK_MUL_D,
        BK_ACC,
        BK_STEER,
        BK_POWER
    } t_back_state;

    // Clamp a wide signed value to the 16-bit power range.
    function automatic logic signed [POWER_W-1:0] sat_power(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-POWER_W:0] top;
        top = v[ACC_W-1:POWER_W-1];
        if (top == '0 || top == '1) begin
            return v[POWER_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(POWER_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POWER_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== hdl/lfps_sample_if.sv =====
// ----------------------------------------------------------------------------
// Line follower PID steering: sample channel
// Valid/ready channel carrying one sensor sample with drive settings.
// ----------------------------------------------------------------------------
interface lfps_sample_if;
    import lfps_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [SAMPLE_W-1:0]      green_sample;
    logic signed [BASE_W-1:0] fwd_speed;
    logic                     edge_select;

    modport source (output valid, green_sample, fwd_speed, edge_select, input ready);
    modport sink   (input valid, green_sample, fwd_speed, edge_select, output ready);
endinterface

// ===== hdl/lfps_power_if.sv =====
// ----------------------------------------------------------------------------
// Line follower PID steering: power channel
// Valid/ready channel carrying motor powers and the steering amount.
// ----------------------------------------------------------------------------
interface lfps_power_if;
    import lfps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POWER_W-1:0] left_power;
    logic signed [POWER_W-1:0] right_power;
    logic signed [POWER_W-1:0] steer_value;

    modport source (output valid, left_power, right_power, steer_value, input ready);
    modport sink   (input valid, left_power, right_power, steer_value, output ready);
endinterface

// ===== hdl/lfps_front.sv =====
// ----------------------------------------------------------------------------
// Line follower PID steering: front end
// Takes sample beats, forms the Q.8 error and the edge sign, pushes a job.
// ----------------------------------------------------------------------------
module lfps_front (
    lfps_sample_if.sink           i_sample_ch,
    input  lfps_pkg::t_sensor_cfg i_sensor_cfg,
    input  lfps_pkg::t_q_stat     i_q_stat,
    output logic                  o_push,
    output lfps_pkg::t_job        o_job
);
    import lfps_pkg::*;

    logic [SAMPLE_W+SCALE_W-1:0] scaled;
    logic signed [ERR_W-1:0]     target_q8;

    assign i_sample_ch.ready = !i_q_stat.full;
    assign o_push            = i_sample_ch.valid && !i_q_stat.full;

    assign scaled    = i_sample_ch.green_sample * i_sensor_cfg.scale;
    assign target_q8 = $signed(ERR_W'({i_sensor_cfg.target, 8'h00}));

    always_comb begin
        o_job.err_q8   = target_q8 - $signed(ERR_W'(scaled));
        o_job.base     = i_sample_ch.fwd_speed;
        o_job.edge_neg = i_sample_ch.edge_select;
    end
endmodule

// ===== hdl/lfps_queue.sv =====
// ----------------------------------------------------------------------------
// Line follower PID steering: job queue
// Short FIFO between the front end and the steering engine.
// ----------------------------------------------------------------------------
module lfps_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lfps_pkg::t_job    i_job,
    input  logic              i_pop,
    output lfps_pkg::t_job    o_job,
    output lfps_pkg::t_q_stat o_stat
);
    import lfps_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
endmodule

// ===== hdl/lfps_back.sv =====
// ----------------------------------------------------------------------------
// Line follower PID steering: steering engine
// Runs P, I and D through one shared multiplier, truncates, saturates,
// drives the power output register and keeps the error history.
// ----------------------------------------------------------------------------
`include "line_follow_pid_steering_macros.svh"

module lfps_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfps_pkg::t_gains  i_gains,
    input  lfps_pkg::t_job    i_job,
    input  lfps_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    lfps_power_if.source      o_power_ch
);
    import lfps_pkg::*;

    t_back_state r_state, n_state;

    t_job                      r_job;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [POWER_W-1:0] r_steer;
    logic signed [HIST_W-1:0]  r_hist [HISTORY_DEPTH];
    logic signed [TRAP_W-1:0]  r_trap;
    logic                      r_first;

    logic                      r_out_valid;
    logic signed [POWER_W-1:0] r_left, r_right, r_steer_out;

    logic                      out_free;
    logic                      load_out;
    logic signed [GAIN_W-1:0]  mul_a;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]   acc_int;
    logic                      acc_frac;
    logic signed [ERR_W-1:0]   err_shr;
    logic signed [HIST_W-1:0]  err_int;
    logic signed [ACC_W-1:0]   base_x, steer_x;
    logic signed [TRAP_W-1:0]  trap_step;

    assign out_free = !r_out_valid || o_power_ch.ready;

    // Sequencer: one item at a time; three multiplies, then add, truncate and saturate, form the powers.
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_MUL_P;
                end
            end
            BK_MUL_P: n_state = BK_MUL_I;
            BK_MUL_I: n_state = BK_MUL_D;
            BK_MUL_D: n_state = BK_ACC;
            BK_ACC:   n_state = BK_STEER;
            BK_STEER: n_state = BK_POWER;
            BK_POWER: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (r_state)
            BK_MUL_P: begin
                mul_a = i_gains.kp;
                mul_b = MULB_W'($signed(r_job.err_q8));
            end
            BK_MUL_I: begin
                mul_a = i_gains.ki;
                mul_b = MULB_W'(r_trap);
            end
            BK_MUL_D: begin
                mul_a = r_first ? '0 : i_gains.kd;
                mul_b = MULB_W'(r_diff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Division by 65536 truncating toward zero.
    assign acc_frac = r_acc[ACC_W-1] && (r_acc[15:0] != '0);
    assign acc_int  = (r_acc >>> 16) + $signed(ACC_W'(acc_frac));

    // Integer error, truncated toward zero.
    assign err_shr = ($signed(r_job.err_q8) >>> 8)
                   + $signed(ERR_W'(r_job.err_q8[ERR_W-1]
                                    && (r_job.err_q8[7:0] != '0)));
    assign err_int = HIST_W'(err_shr);

    assign base_x  = ACC_W'(r_job.base);
    assign steer_x = ACC_W'(r_steer);

    // The trapezoid sum moves by the new error plus the old head, less the two
    // oldest entries.
    assign trap_step = TRAP_W'(err_int) + TRAP_W'(r_hist[0])
                     - TRAP_W'(r_hist[HISTORY_DEPTH-2])
                     - TRAP_W'(r_hist[HISTORY_DEPTH-1]);

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    r_job <= i_job;
                end
            end
            BK_MUL_P: begin
                r_prod <= mul_p;
                r_acc  <= '0;
                r_diff <= DIFF_W'($signed(r_job.err_q8)) - (DIFF_W'(r_hist[0]) <<< 8);
            end
            BK_MUL_I: begin
                r_prod <= mul_p;
                r_acc  <= r_acc + ACC_W'(r_prod);
            end
            BK_MUL_D: begin
                r_prod <= mul_p;
                r_acc  <= r_acc + (ACC_W'(r_prod) <<< 8);
            end
            BK_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            BK_STEER: begin
                r_steer <= sat_power(acc_int);
            end
            default: begin
            end
        endcase
    end

    // Error history, running trapezoid sum and first-sample flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_trap  <= '0;
            r_first <= 1'b1;
        end else if (load_out) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= err_int;
            r_trap    <= r_trap + trap_step;
            r_first   <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_power_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_steer_out <= r_steer;
            if (r_job.edge_neg) begin
                r_left  <= sat_power(base_x - steer_x);
                r_right <= sat_power(base_x + steer_x);
            end else begin
                r_left  <= sat_power(base_x + steer_x);
                r_right <= sat_power(base_x - steer_x);
            end
        end
    end

    assign o_power_ch.valid       = r_out_valid;
    assign o_power_ch.left_power  = r_left;
    assign o_power_ch.right_power = r_right;
    assign o_power_ch.steer_value = r_steer_out;

    `LFPS_ASSERT_NXT(a_pop_starts_item, i_clk, i_rst_n, o_pop, r_state == BK_MUL_P)
    `LFPS_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, load_out, r_out_valid && !r_first)
    `LFPS_ASSERT_NXT(a_hist_shifts, i_clk, i_rst_n, load_out, r_hist[1] == $past(r_hist[0]))
    `LFPS_ASSERT_IMP(a_valid_after_first, i_clk, i_rst_n, r_out_valid, !r_first)
endmodule

// ===== hdl/line_follow_pid_steering.sv =====
// ----------------------------------------------------------------------------
// Line follower PID steering: top level
// Configuration registers, front end, job queue and steering engine.
//
//   channel      direction  beat contents
//   i_sample_ch  in         green_sample, fwd_speed, edge_select
//   o_power_ch   out        left_power, right_power, steer_value
//   i_cfg_*      in         write enable, register index, write data
//
// Each sample passes seven steps in the steering engine: fetching the job,
// three passes through the shared 16 x 25 multiplier, adding the last
// product, truncating and saturating, and forming the powers.
// A two-entry queue lets the front end take samples while the engine works.
// Reset is synchronous; it clears the error history and sets the first-sample
// flag, so the derivative term of the first beat is zero.
// A stalled output holds its beat and the engine waits in its last step.
// ----------------------------------------------------------------------------
module line_follow_pid_steering (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lfps_sample_if.sink                     i_sample_ch,
    lfps_power_if.source                    o_power_ch,
    input  logic                            i_cfg_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lfps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lfps_pkg::*;

    t_sensor_cfg r_sensor_cfg;
    t_gains      r_gains;
    t_job        push_job, head_job;
    t_q_stat     q_stat;
    logic        push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_cfg.target <= TARGET_RESET;
            r_sensor_cfg.scale  <= SCALE_RESET;
            r_gains.kp          <= KP_RESET;
            r_gains.ki          <= KI_RESET;
            r_gains.kd          <= KD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET: r_sensor_cfg.target <= i_cfg_data[TARGET_W-1:0];
                CFG_SCALE:  r_sensor_cfg.scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_KP:     r_gains.kp          <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:     r_gains.ki          <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:     r_gains.kd          <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lfps_front u_front (
        .i_sample_ch  (i_sample_ch),
        .i_sensor_cfg (r_sensor_cfg),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_job        (push_job)
    );

    lfps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    lfps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_gains    (r_gains),
        .i_job      (head_job),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_power_ch (o_power_ch)
    );
endmodule

// ===== bench/line_follow_pid_steering_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PID steering: testbench
// Drives sensor beats and register writes into the steering block and checks
// every power beat against a cycle-free model of the PID law kept here: error
// against the target, trapezoid integral over the error history, derivative
// suppressed on the first beat after reset, and saturation of all outputs.
// A short table of hand-picked beats comes first, then phases of random
// beats under random register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_test;
    import lfps_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 100;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 108;
    localparam int PLAN_ROWS     = 33;
    localparam longint POWER_MAX = 32767;
    localparam longint POWER_MIN = -32768;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_KD + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef struct packed {
        logic signed [POWER_W-1:0] left_pw;
        logic signed [POWER_W-1:0] right_pw;
        logic signed [POWER_W-1:0] steer;
    } t_power_beat;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_data;
        logic [SAMPLE_W-1:0]      green;
        logic signed [BASE_W-1:0] base;
        logic                     edge_sel;
        logic                     known;
        t_power_beat              typed;
    } t_plan_row;

    // Rows marked known carry the powers that follow directly from the law;
    // the others are left to the model.
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        '{ROW_CFG,    CFG_KD,       'h0100, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      0,    0,    0, 1, '{80, -80, 80}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      1023, 5,    1, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KD,       'h0000, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      1023, -128, 1, 1, '{815, -1071, -943}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      80,   127,  0, 1, '{127, 127, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      512,  100,  1, 1, '{532, -332, -432}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      160,  -100, 0, 1, '{-180, -20, -80}},
        '{ROW_CFG,    CFG_SPARE_LO, 'h0000, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_SPARE_HI, 'hFFFF, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      0,    -1,   0, 1, '{79, -81, 80}},
        '{ROW_CFG,    CFG_TARGET,   'hFFFF, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_SCALE,    'hFFFF, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KP,       'h8000, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KI,       'h7FFF, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KD,       'h8000, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      0,    127,  0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      1023, -128, 1, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      1023, 127,  0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      0,    -128, 1, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KP,       'h7FFF, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KI,       'h8000, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KD,       'h7FFF, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_TARGET,   'h0000, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      1023, 127,  1, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      0,    -128, 0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      600,  50,   0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KP,       'h0000, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KI,       'h0000, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_CFG,    CFG_KD,       'h0000, 0,    0,    0, 0, '{0, 0, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      1023, -128, 1, 1, '{-128, -128, 0}},
        '{ROW_SAMPLE, CFG_TARGET,   0,      0,    127,  0, 1, '{127, 127, 0}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lfps_sample_if sample_ch ();
    lfps_power_if  power_ch ();

    line_follow_pid_steering dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_power_ch  (power_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Controller state as the block should hold it.
    logic [TARGET_W-1:0]       ctl_target;
    logic [SCALE_W-1:0]        ctl_scale;
    logic signed [GAIN_W-1:0]  ctl_kp;
    logic signed [GAIN_W-1:0]  ctl_ki;
    logic signed [GAIN_W-1:0]  ctl_kd;
    logic signed [HIST_W-1:0]  err_hist [HISTORY_DEPTH];
    logic                      awaiting_first;

    t_power_beat power_due [$];
    t_power_beat typed_beat;
    logic        typed_ok;
    logic        tx_idle_on;
    logic        rx_idle_on;
    int          rx_hold = 0;
    int          fault_cnt = 0;
    int unsigned cycle_cnt = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint clamp16(input longint v);
        if (v > POWER_MAX) return POWER_MAX;
        if (v < POWER_MIN) return POWER_MIN;
        return v;
    endfunction

    // One control tick: forms the steering from the current error and the
    // history, then shifts the truncated error into the history.
    function automatic t_power_beat pid_steer_update(
        input logic [SAMPLE_W-1:0]     green,
        input logic signed [BASE_W-1:0] base,
        input logic                     edge_sel
    );
        longint      err_q8;
        longint      trap_sum;
        longint      d_term;
        longint      acc;
        longint      steer;
        longint      sgn;
        t_power_beat beat;
        err_q8 = longint'(ctl_target) * 256 - longint'(green) * longint'(ctl_scale);
        trap_sum = 0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            trap_sum += ((i == 0 || i == HISTORY_DEPTH - 1) ? 1 : 2) * longint'(err_hist[i]);
        end
        d_term = 0;
        if (!awaiting_first) begin
            d_term = longint'(ctl_kd) * (err_q8 - longint'(err_hist[0]) * 256);
        end
        awaiting_first = 1'b0;
        acc = longint'(ctl_kp) * err_q8 + longint'(ctl_ki) * trap_sum * 256 + d_term;
        steer = clamp16(acc / 65536);
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            err_hist[i] = err_hist[i-1];
        end
        err_hist[0] = HIST_W'(clamp16(err_q8 / 256));
        sgn = edge_sel ? -1 : 1;
        beat.left_pw  = POWER_W'(clamp16(longint'(base) + sgn * steer));
        beat.right_pw = POWER_W'(clamp16(longint'(base) - sgn * steer));
        beat.steer    = POWER_W'(steer);
        return beat;
    endfunction

    task automatic check_field(input string name, input logic signed [POWER_W-1:0] want,
                               input logic signed [POWER_W-1:0] got);
        if (got !== want) begin
            if (fault_cnt < MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
            fault_cnt++;
        end
    endtask

    // Output beats are checked before the input beat of the same edge is
    // predicted, so the oldest expectation is always the one compared.
    always @(posedge i_clk) begin : beat_monitor
        t_power_beat got;
        t_power_beat want;
        t_power_beat pred;
        if (i_rst_n) begin
            if (power_ch.valid && power_ch.ready) begin
                got = '{power_ch.left_power, power_ch.right_power, power_ch.steer_value};
                if (power_due.size() == 0) begin
                    if (fault_cnt < MAX_REPORTS) begin
                        $display("%0t ns: power beat with none expected, actual %0d %0d %0d",
                                 $time, got.left_pw, got.right_pw, got.steer);
                    end
                    fault_cnt++;
                end else begin
                    want = power_due.pop_front();
                    check_field("left_power", want.left_pw, got.left_pw);
                    check_field("right_power", want.right_pw, got.right_pw);
                    check_field("steer_value", want.steer, got.steer);
                end
            end
            if (sample_ch.valid && sample_ch.ready) begin
                pred = pid_steer_update(sample_ch.green_sample, sample_ch.fwd_speed,
                                        sample_ch.edge_select);
                power_due.push_back(typed_ok ? typed_beat : pred);
            end
        end
    end

    // Receiver: ready drops at random while idling is on.
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            power_ch.ready <= 1'b0;
            rx_hold        <= $urandom_range(0, 16);
        end else begin
            power_ch.ready <= 1'b1;
            rx_hold        <= $urandom_range(0, 23);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TARGET: ctl_target = data[TARGET_W-1:0];
            CFG_SCALE:  ctl_scale  = data[SCALE_W-1:0];
            CFG_KP:     ctl_kp     = data;
            CFG_KI:     ctl_ki     = data;
            CFG_KD:     ctl_kd     = data;
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] green,
                               input logic signed [BASE_W-1:0] base,
                               input logic edge_sel, input logic known,
                               input t_power_beat typed);
        i_cfg_we <= 1'b0;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.green_sample <= green;
        sample_ch.fwd_speed    <= base;
        sample_ch.edge_select  <= edge_sel;
        typed_ok               <= known;
        typed_beat             <= typed;
        do @(posedge i_clk); while (!sample_ch.ready);
    endtask

    // Stops the sender and waits until every expected beat has come out.
    // The first edge lets the monitor record a beat accepted just before.
    task automatic settle_engine();
        sample_ch.valid <= 1'b0;
        i_cfg_we        <= 1'b0;
        @(posedge i_clk);
        while (power_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_level(input logic [CFG_DATA_W-1:0] nominal);
        case ($urandom_range(0, 5))
            0:       return {CFG_DATA_W{1'b0}};
            1:       return {6'($urandom), {TARGET_W{1'b1}}};
            2:       return nominal;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Moderate gains keep the loop out of saturation often enough to see
    // the integral and derivative terms at work.
    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int v;
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3, 4, 5: begin
                v = int'($urandom_range(0, 1024)) - 512;
                return CFG_DATA_W'(v);
            end
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    initial begin
        int                       b;
        logic [SAMPLE_W-1:0]      green;
        logic signed [BASE_W-1:0] base;

        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_TARGET;
        i_cfg_data             = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.green_sample = '0;
        sample_ch.fwd_speed    = '0;
        sample_ch.edge_select  = 1'b0;
        power_ch.ready         = 1'b0;
        typed_ok               = 1'b0;
        typed_beat             = '0;
        tx_idle_on             = 1'b1;
        rx_idle_on             = 1'b1;
        ctl_target             = TARGET_RESET;
        ctl_scale              = SCALE_RESET;
        ctl_kp                 = KP_RESET;
        ctl_ki                 = KI_RESET;
        ctl_kd                 = KD_RESET;
        awaiting_first         = 1'b1;
        for (int i = 0; i < HISTORY_DEPTH; i++) err_hist[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].kind == ROW_CFG) begin
                if (r > 0 && PLAN[r-1].kind == ROW_SAMPLE) settle_engine();
                write_reg(PLAN[r].reg_idx, PLAN[r].reg_data);
            end else begin
                send_sample(PLAN[r].green, PLAN[r].base, PLAN[r].edge_sel,
                            PLAN[r].known, PLAN[r].typed);
            end
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            settle_engine();
            // Every fourth phase and the last one run without any idling.
            tx_idle_on = (phase != RAND_PHASES - 1) && (phase % 4 != 2);
            rx_idle_on = tx_idle_on;
            write_reg(CFG_TARGET, pick_level(CFG_DATA_W'(TARGET_RESET)));
            write_reg(CFG_SCALE, pick_level(CFG_DATA_W'(SCALE_RESET)));
            write_reg(CFG_KP, pick_gain());
            write_reg(CFG_KI, pick_gain());
            write_reg(CFG_KD, pick_gain());
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          CFG_DATA_W'($urandom));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2) settle_engine();
                case ($urandom_range(0, 7))
                    0:       green = '0;
                    1:       green = '1;
                    default: green = SAMPLE_W'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    base = BASE_W'($urandom);
                end else begin
                    b    = int'($urandom_range(0, 200)) - 100;
                    base = BASE_W'(b);
                end
                send_sample(green, base, 1'($urandom), 1'b0, '0);
            end
        end

        settle_engine();
        if (fault_cnt == 0 && power_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
